// File: rtl/dpp_pkg.sv
package dpp_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] REG_PRINC_COL = 3'd0;
	localparam logic [2:0] REG_PRINC_ROW = 3'd1;
	localparam logic [2:0] REG_INV_FX    = 3'd2;
	localparam logic [2:0] REG_INV_FY    = 3'd3;
	localparam logic [2:0] REG_ROW_X     = 3'd4;
	localparam logic [2:0] REG_ROW_Y     = 3'd5;
	localparam logic [2:0] REG_ROW_Z     = 3'd6;
	localparam logic [2:0] REG_SHIFT     = 3'd7;

	localparam logic signed [63:0] POINT_MAX = 64'sd524287;
	localparam logic signed [63:0] POINT_MIN = -64'sd524288;

	localparam logic [2:0] CAM_STEP_LAST = 3'd5;
	localparam logic [2:0] ROW_TERM_LAST = 3'd4;
	localparam logic [1:0] ROW_LAST      = 2'd2;

	typedef struct packed {
		logic [15:0] princ_col;
		logic [15:0] princ_row;
		logic [23:0] inv_fx;
		logic [23:0] inv_fy;
		logic [63:0] row_x;
		logic [63:0] row_y;
		logic [63:0] row_z;
		logic [1:0]  shift;
	} cfg_t;

	typedef struct packed {
		logic        clear;
		logic        keep;
		logic [11:0] row;
		logic [11:0] col;
		logic [15:0] depth;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} item_t;

	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] z;
		logic [7:0]         label;
		logic               overflow;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MATH,
		ST_HOLD
	} back_state_t;

endpackage

// File: rtl/depth_pixel_to_point_with_label.sv
// Depth pixel to labelled 3-D point.
// Slave stream: one depth pixel per transfer. A pixel on the sampling grid
// with nonzero depth and mask yields one point on the master stream; any
// other pixel yields nothing. s_tuser set clears the colour table before
// the pixel, whether the pixel is kept or not.
// Dropped pixels are taken one per cycle while the queue is not full. A
// kept pixel goes through the engine in order: it is pulled from the queue,
// the colour table is searched (one table read per cycle), the shared
// 18x25 multiplier does both the pinhole projection and the 3x4 transform
// (21 partial products, each multiplied and then accumulated), and the
// output register is loaded. A 4-entry queue sits between the input side
// and this engine, so the input keeps taking pixels while the engine works.
// The result sits in an output register; while m_tready is low the engine
// holds its finished point and the queue fills, then s_tready drops.
// Reset empties the queue and the output, sets sample_shift to 1, the other
// registers to 0, and the colour table to empty.
// Registers sit at byte address 8*i, written in the APB access phase.
module depth_pixel_to_point_with_label #(
	parameter int MAX_LABELS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pixel_row, pixel_col, depth_mm, mask_value, seg_red, seg_green, seg_blue
	input  logic [71:0] s_tdata,
	// frame_start
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// point_x, point_y, point_z, seg_label, out_red, out_green, out_blue, zero pad
	output logic [95:0] m_tdata,
	// label_overflow
	output logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_LABELS + 1);

	dpp_pkg::cfg_t    cfg_q;
	dpp_pkg::item_t   push_item;
	dpp_pkg::item_t   pop_item;
	dpp_pkg::result_t back_res;
	dpp_pkg::result_t out_q;
	logic             out_v_q;
	logic             push;
	logic             queue_full;
	logic             queue_empty;
	logic             pop;
	logic             out_load;
	logic             out_free;
	logic [CW-1:0]    label_count;
	logic [2:0]       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.princ_col <= '0;
			cfg_q.princ_row <= '0;
			cfg_q.inv_fx    <= '0;
			cfg_q.inv_fy    <= '0;
			cfg_q.row_x     <= '0;
			cfg_q.row_y     <= '0;
			cfg_q.row_z     <= '0;
			cfg_q.shift     <= 2'd1;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				dpp_pkg::REG_PRINC_COL: cfg_q.princ_col <= pwdata[15:0];
				dpp_pkg::REG_PRINC_ROW: cfg_q.princ_row <= pwdata[15:0];
				dpp_pkg::REG_INV_FX:    cfg_q.inv_fx    <= pwdata[23:0];
				dpp_pkg::REG_INV_FY:    cfg_q.inv_fy    <= pwdata[23:0];
				dpp_pkg::REG_ROW_X:     cfg_q.row_x     <= pwdata;
				dpp_pkg::REG_ROW_Y:     cfg_q.row_y     <= pwdata;
				dpp_pkg::REG_ROW_Z:     cfg_q.row_z     <= pwdata;
				default:                cfg_q.shift     <= pwdata[1:0];
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dpp_pkg::REG_PRINC_COL: prdata = {48'd0, cfg_q.princ_col};
			dpp_pkg::REG_PRINC_ROW: prdata = {48'd0, cfg_q.princ_row};
			dpp_pkg::REG_INV_FX:    prdata = {40'd0, cfg_q.inv_fx};
			dpp_pkg::REG_INV_FY:    prdata = {40'd0, cfg_q.inv_fy};
			dpp_pkg::REG_ROW_X:     prdata = cfg_q.row_x;
			dpp_pkg::REG_ROW_Y:     prdata = cfg_q.row_y;
			dpp_pkg::REG_ROW_Z:     prdata = cfg_q.row_z;
			default:                prdata = {62'd0, cfg_q.shift};
		endcase
	end

	dpp_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.shift      (cfg_q.shift),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	dpp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (queue_empty)
	);

	dpp_back #(
		.MAX_LABELS (MAX_LABELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (!queue_empty),
		.in_item     (pop_item),
		.in_pop      (pop),
		.out_free    (out_free),
		.out_load    (out_load),
		.out_res     (back_res),
		.label_count (label_count)
	);

	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= back_res;
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.overflow;
	assign m_tdata  = {4'h0, out_q.blue, out_q.green, out_q.red, out_q.label,
			out_q.z, out_q.y, out_q.x};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			label_count <= CW'(MAX_LABELS))
		else $error("label count beyond table size");

	a_ovf_label: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid && m_tuser |-> m_tdata[67:60] == 8'h00)
		else $error("overflow point carries a nonzero label");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
			out_load |-> (!out_v_q || m_tready))
		else $error("result loaded over a pending transfer");

endmodule

// File: rtl/dpp_front.sv
module dpp_front (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [71:0]       s_tdata,
	input  logic              s_tuser,
	input  logic [1:0]        shift,
	input  logic              queue_full,
	output logic              push,
	output dpp_pkg::item_t    push_item
);

	logic [2:0] step_mask;
	logic       on_grid;
	logic       keep;

	always_comb begin
		case (shift)
			2'd0: step_mask = 3'b000;
			2'd1: step_mask = 3'b001;
			2'd2: step_mask = 3'b011;
			default: step_mask = 3'b111;
		endcase
	end

	assign on_grid = ((s_tdata[2:0] & step_mask) == 3'b000) &&
			((s_tdata[14:12] & step_mask) == 3'b000);
	assign keep = on_grid && (s_tdata[39:24] != 16'd0) && (s_tdata[47:40] != 8'd0);

	assign s_tready = !queue_full;
	// queue only what the back end must see: kept pixels and table clears
	assign push = s_tvalid && !queue_full && (keep || s_tuser);

	always_comb begin
		push_item.clear = s_tuser;
		push_item.keep  = keep;
		push_item.row   = s_tdata[11:0];
		push_item.col   = s_tdata[23:12];
		push_item.depth = s_tdata[39:24];
		push_item.red   = s_tdata[55:48];
		push_item.green = s_tdata[63:56];
		push_item.blue  = s_tdata[71:64];
	end

endmodule

// File: rtl/dpp_fifo.sv
module dpp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dpp_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output dpp_pkg::item_t pop_item,
	output logic           empty
);

	localparam int AW = $clog2(dpp_pkg::QUEUE_DEPTH);

	dpp_pkg::item_t     entry_q [dpp_pkg::QUEUE_DEPTH];
	logic [AW-1:0]      wr_ptr_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [AW:0]        level_q;

	assign full     = (level_q == (AW+1)'(dpp_pkg::QUEUE_DEPTH));
	assign empty    = (level_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push && !full) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop && !empty) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push && !full, pop && !empty})
				2'b10: level_q <= level_q + 1'b1;
				2'b01: level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

// File: rtl/dpp_back.sv
module dpp_back #(
	parameter int MAX_LABELS = 256,
	parameter int AW = $clog2(MAX_LABELS),
	parameter int CW = $clog2(MAX_LABELS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dpp_pkg::cfg_t    cfg,
	input  logic             in_valid,
	input  dpp_pkg::item_t   in_item,
	output logic             in_pop,
	input  logic             out_free,
	output logic             out_load,
	output dpp_pkg::result_t out_res,
	output logic [CW-1:0]    label_count
);

	dpp_pkg::back_state_t state_q, state_d;

	dpp_pkg::item_t   item_q;
	logic [23:0]      key;
	logic [23:0]      mem [MAX_LABELS];
	logic [23:0]      rd_data_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    cmp_idx_q;
	logic             cmp_v_q;
	logic [CW-1:0]    lab_q;
	logic             ovf_q;
	logic             hit;
	logic             scan_done;
	logic             table_full;

	logic             acc_ph_q;
	logic             row_ph_q;
	logic [2:0]       step_q;
	logic [2:0]       term_q;
	logic [1:0]       row_q;
	logic             math_done;

	logic signed [17:0] dx;
	logic signed [17:0] dy;
	logic signed [33:0] tx_q, ty_q;
	logic signed [37:0] camx_q, camy_q;
	logic signed [19:0] px_q, py_q, pz_q;
	logic signed [63:0] acc_q;
	logic signed [42:0] prod_q;
	logic signed [17:0] op_a;
	logic signed [24:0] op_b;
	logic [4:0]         sh;
	logic [63:0]        row_word;
	logic signed [63:0] sum;
	logic signed [63:0] scaled;
	logic signed [19:0] sat;
	logic [CW+7:0]      lab_ext;

	assign key = {item_q.red, item_q.green, item_q.blue};
	assign label_count = count_q;
	assign hit = cmp_v_q && (rd_data_q == key);
	assign scan_done = (idx_q == count_q);
	assign table_full = (count_q == CW'(MAX_LABELS));

	assign dx = 18'(signed'({2'b00, item_q.col, 4'b0000})) - 18'(signed'({2'b00, cfg.princ_col}));
	assign dy = 18'(signed'({2'b00, item_q.row, 4'b0000})) - 18'(signed'({2'b00, cfg.princ_row}));

	always_comb begin
		case (row_q)
			2'd0: row_word = cfg.row_x;
			2'd1: row_word = cfg.row_y;
			default: row_word = cfg.row_z;
		endcase
	end

	// operand and shift select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		sh   = 5'd0;
		if (!row_ph_q) begin
			case (step_q)
				3'd0: begin op_a = dx; op_b = 25'(signed'({1'b0, item_q.depth})); end
				3'd1: begin op_a = dy; op_b = 25'(signed'({1'b0, item_q.depth})); end
				3'd2: begin op_a = 18'(signed'({1'b0, tx_q[16:0]})); op_b = {1'b0, cfg.inv_fx}; end
				3'd3: begin
					op_a = 18'(signed'(tx_q[33:17]));
					op_b = {1'b0, cfg.inv_fx};
					sh = 5'd17;
				end
				3'd4: begin op_a = 18'(signed'({1'b0, ty_q[16:0]})); op_b = {1'b0, cfg.inv_fy}; end
				default: begin
					op_a = 18'(signed'(ty_q[33:17]));
					op_b = {1'b0, cfg.inv_fy};
					sh = 5'd17;
				end
			endcase
		end else begin
			case (term_q)
				3'd0: begin op_a = 18'(signed'(row_word[15:0])); op_b = {1'b0, camx_q[23:0]}; end
				3'd1: begin
					op_a = 18'(signed'(row_word[15:0]));
					op_b = 25'(signed'(camx_q[37:24]));
					sh = 5'd24;
				end
				3'd2: begin op_a = 18'(signed'(row_word[31:16])); op_b = {1'b0, camy_q[23:0]}; end
				3'd3: begin
					op_a = 18'(signed'(row_word[31:16]));
					op_b = 25'(signed'(camy_q[37:24]));
					sh = 5'd24;
				end
				default: begin
					op_a = 18'(signed'(row_word[47:32]));
					op_b = 25'(signed'({1'b0, item_q.depth, 8'h00}));
				end
			endcase
		end
	end

	always_comb begin
		sum = acc_q + (64'(prod_q) <<< sh);
		if (row_ph_q && term_q == 3'd0)
			sum = 64'(prod_q) + (64'(signed'(row_word[63:48])) <<< 22) + (64'sd1 <<< 21);
		else if (!row_ph_q && (step_q == 3'd2 || step_q == 3'd4))
			sum = 64'(prod_q) + (64'sd1 <<< 19);
		scaled = sum >>> 22;
		if (scaled > dpp_pkg::POINT_MAX) sat = 20'sh7FFFF;
		else if (scaled < dpp_pkg::POINT_MIN) sat = -20'sh80000;
		else sat = scaled[19:0];
	end

	assign math_done = acc_ph_q && row_ph_q && term_q == dpp_pkg::ROW_TERM_LAST &&
			row_q == dpp_pkg::ROW_LAST;

	always_comb begin
		state_d  = state_q;
		in_pop   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			dpp_pkg::ST_IDLE: begin
				in_pop = in_valid;
				if (in_valid && in_item.keep) state_d = dpp_pkg::ST_SEARCH;
			end
			dpp_pkg::ST_SEARCH: begin
				if (hit || scan_done) state_d = dpp_pkg::ST_MATH;
			end
			dpp_pkg::ST_MATH: begin
				if (math_done) state_d = dpp_pkg::ST_HOLD;
			end
			dpp_pkg::ST_HOLD: begin
				out_load = out_free;
				if (out_free) state_d = dpp_pkg::ST_IDLE;
			end
			default: state_d = dpp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dpp_pkg::ST_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			cmp_v_q  <= 1'b0;
			acc_ph_q <= 1'b0;
			row_ph_q <= 1'b0;
			step_q   <= '0;
			term_q   <= '0;
			row_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				dpp_pkg::ST_IDLE: begin
					if (in_valid && in_item.clear) count_q <= '0;
					idx_q    <= '0;
					cmp_v_q  <= 1'b0;
					acc_ph_q <= 1'b0;
					row_ph_q <= 1'b0;
					step_q   <= '0;
					term_q   <= '0;
					row_q    <= '0;
				end
				dpp_pkg::ST_SEARCH: begin
					if (!hit && scan_done && !table_full) count_q <= count_q + 1'b1;
					if (!hit && !scan_done) begin
						idx_q   <= idx_q + 1'b1;
						cmp_v_q <= 1'b1;
					end else begin
						cmp_v_q <= 1'b0;
					end
				end
				dpp_pkg::ST_MATH: begin
					acc_ph_q <= !acc_ph_q;
					if (acc_ph_q) begin
						if (!row_ph_q) begin
							if (step_q == dpp_pkg::CAM_STEP_LAST) row_ph_q <= 1'b1;
							else step_q <= step_q + 1'b1;
						end else if (term_q == dpp_pkg::ROW_TERM_LAST) begin
							term_q <= '0;
							row_q  <= row_q + 1'b1;
						end else begin
							term_q <= term_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dpp_pkg::ST_IDLE && in_valid) item_q <= in_item;
		if (state_q == dpp_pkg::ST_SEARCH) begin
			if (!hit && !scan_done) begin
				rd_data_q <= mem[idx_q[AW-1:0]];
				cmp_idx_q <= idx_q;
			end
			if (hit) begin
				lab_q <= cmp_idx_q;
				ovf_q <= 1'b0;
			end else if (scan_done) begin
				if (table_full) begin
					lab_q <= '0;
					ovf_q <= 1'b1;
				end else begin
					mem[count_q[AW-1:0]] <= key;
					lab_q <= count_q;
					ovf_q <= 1'b0;
				end
			end
		end
		if (state_q == dpp_pkg::ST_MATH) begin
			if (!acc_ph_q) begin
				prod_q <= 43'(op_a * op_b);
			end else if (!row_ph_q) begin
				case (step_q)
					3'd0: tx_q <= prod_q[33:0];
					3'd1: ty_q <= prod_q[33:0];
					3'd3: camx_q <= 38'(sum >>> 20);
					3'd5: camy_q <= 38'(sum >>> 20);
					default: acc_q <= sum;
				endcase
			end else if (term_q == dpp_pkg::ROW_TERM_LAST) begin
				case (row_q)
					2'd0: px_q <= sat;
					2'd1: py_q <= sat;
					default: pz_q <= sat;
				endcase
			end else begin
				acc_q <= sum;
			end
		end
	end

	assign lab_ext = {8'h00, lab_q};

	always_comb begin
		out_res.x        = px_q;
		out_res.y        = py_q;
		out_res.z        = pz_q;
		out_res.label    = lab_ext[7:0];
		out_res.overflow = ovf_q;
		out_res.red      = item_q.red;
		out_res.green    = item_q.green;
		out_res.blue     = item_q.blue;
	end

endmodule

// File: tb/depth_pixel_to_point_with_label_tb.sv
`timescale 1ns / 100ps

module depth_pixel_to_point_with_label_tb;

	typedef struct {
		logic [11:0] row;
		logic [11:0] col;
		logic [15:0] depth;
		logic [7:0]  mask;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        frame_start;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	depth_pixel_to_point_with_label u_top (.*);

	// camera and transform settings as the block should hold them
	logic [15:0] cam_cx = '0, cam_cy = '0;
	logic [23:0] cam_ifx = '0, cam_ify = '0;
	logic [63:0] xform [3] = '{default: '0};
	logic [1:0]  grid_shift = 2'd1;
	logic [23:0] colour_tab [256];
	int unsigned colour_cnt = 0;

	pixel_t           pixel_q [$];
	dpp_pkg::result_t point_q [$];
	pixel_t           cur_pixel;
	int      send_idle = 0, recv_stall = 0;
	int      errors = 0, points_seen = 0, pixels_sent = 0, overflows_seen = 0;

	initial forever #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [19:0] row_point(logic [63:0] r, longint cx, longint cy,
			longint cz);
		longint acc;
		acc = longint'($signed(r[15:0])) * cx + longint'($signed(r[31:16])) * cy
			+ longint'($signed(r[47:32])) * cz + (longint'($signed(r[63:48])) <<< 22);
		acc = (acc + (64'sd1 <<< 21)) >>> 22;
		if (acc > 524287) acc = 524287;
		if (acc < -524288) acc = -524288;
		return acc[19:0];
	endfunction

	function automatic void project_pixel(pixel_t p);
		logic [11:0]      step_mask;
		logic [23:0]      key;
		longint           dx, dy, cx, cy, cz;
		int               lbl;
		bit               hit;
		dpp_pkg::result_t res;
		step_mask = 12'((1 << grid_shift) - 1);
		hit = 0;
		lbl = 0;
		if (p.frame_start) colour_cnt = 0;
		if ((p.row & step_mask) != 12'd0 || (p.col & step_mask) != 12'd0
				|| p.depth == 0 || p.mask == 0)
			return;
		dx = longint'(p.col) * 16 - longint'(cam_cx);
		dy = longint'(p.row) * 16 - longint'(cam_cy);
		cx = (dx * longint'(p.depth) * longint'(cam_ifx) + (64'sd1 <<< 19)) >>> 20;
		cy = (dy * longint'(p.depth) * longint'(cam_ify) + (64'sd1 <<< 19)) >>> 20;
		cz = longint'(p.depth) * 256;
		key = {p.red, p.green, p.blue};
		for (int k = 0; k < colour_cnt; k++) begin
			if (!hit && colour_tab[k] == key) begin
				hit = 1;
				lbl = k;
			end
		end
		res.overflow = 1'b0;
		if (!hit) begin
			if (colour_cnt < 256) begin
				colour_tab[colour_cnt] = key;
				lbl = colour_cnt;
				colour_cnt++;
			end else begin
				res.overflow = 1'b1;
			end
		end
		res.x = row_point(xform[0], cx, cy, cz);
		res.y = row_point(xform[1], cx, cy, cz);
		res.z = row_point(xform[2], cx, cy, cz);
		res.label = lbl[7:0];
		res.red = p.red;
		res.green = p.green;
		res.blue = p.blue;
		point_q = {point_q, res};
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				project_pixel(cur_pixel);
				pixels_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur_pixel = pixel_q.pop_front();
					s_tdata <= {cur_pixel.blue, cur_pixel.green, cur_pixel.red, cur_pixel.mask,
						cur_pixel.depth, cur_pixel.col, cur_pixel.row};
					s_tuser <= cur_pixel.frame_start;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		dpp_pkg::result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				points_seen++;
				if (m_tuser) overflows_seen++;
				if (point_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected point %h user %b", m_tdata, m_tuser);
				end else begin
					want = point_q.pop_front();
					if (m_tdata[19:0] !== want.x || m_tdata[39:20] !== want.y
							|| m_tdata[59:40] !== want.z || m_tdata[67:60] !== want.label
							|| m_tdata[75:68] !== want.red || m_tdata[83:76] !== want.green
							|| m_tdata[91:84] !== want.blue || m_tuser !== want.overflow) begin
						errors++;
						if (errors <= 10)
							$display("point mismatch: exp x %h y %h z %h lbl %h ovf %b rgb %h%h%h, got %h user %b",
								want.x, want.y, want.z, want.label, want.overflow,
								want.red, want.green, want.blue, m_tdata, m_tuser);
					end
				end
			end
			m_tready <= $urandom_range(99) >= recv_stall;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			dpp_pkg::REG_PRINC_COL: cam_cx = val[15:0];
			dpp_pkg::REG_PRINC_ROW: cam_cy = val[15:0];
			dpp_pkg::REG_INV_FX:    cam_ifx = val[23:0];
			dpp_pkg::REG_INV_FY:    cam_ify = val[23:0];
			dpp_pkg::REG_ROW_X:     xform[0] = val;
			dpp_pkg::REG_ROW_Y:     xform[1] = val;
			dpp_pkg::REG_ROW_Z:     xform[2] = val;
			dpp_pkg::REG_SHIFT:     grid_shift = val[1:0];
			default: ;
		endcase
	endtask

	task automatic set_camera(logic [15:0] cx, logic [15:0] cy, logic [23:0] ifx,
			logic [23:0] ify, logic [63:0] rx, logic [63:0] ry, logic [63:0] rz,
			logic [1:0] sh);
		reg_write(dpp_pkg::REG_PRINC_COL, {48'd0, cx});
		reg_write(dpp_pkg::REG_PRINC_ROW, {48'd0, cy});
		reg_write(dpp_pkg::REG_INV_FX, {40'd0, ifx});
		reg_write(dpp_pkg::REG_INV_FY, {40'd0, ify});
		reg_write(dpp_pkg::REG_ROW_X, rx);
		reg_write(dpp_pkg::REG_ROW_Y, ry);
		reg_write(dpp_pkg::REG_ROW_Z, rz);
		reg_write(dpp_pkg::REG_SHIFT, {62'd0, sh});
	endtask

	task automatic add_pixel(int row, int col, int depth, int mask, logic [23:0] rgb, bit fs);
		pixel_t p;
		p.row = 12'(row);
		p.col = 12'(col);
		p.depth = 16'(depth);
		p.mask = 8'(mask);
		{p.red, p.green, p.blue} = rgb;
		p.frame_start = fs;
		pixel_q = {pixel_q, p};
	endtask

	// mostly grid pixels with a small palette, some noise and off-grid drops
	task automatic add_random(int n);
		int sel;
		int step;
		logic [23:0] rgb;
		step = 1 << grid_shift;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			rgb = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(11) * 24'h151a3d);
			if (sel < 75)
				add_pixel($urandom_range(4095) & ~(step - 1), $urandom_range(4095) & ~(step - 1),
					$urandom_range(65535, 1), $urandom_range(255, 1), rgb,
					$urandom_range(99) < 3);
			else
				add_pixel($urandom_range(4095), $urandom_range(4095),
					($urandom_range(3) == 0) ? 0 : $urandom_range(65535),
					($urandom_range(3) == 0) ? 0 : $urandom_range(255), rgb,
					$urandom_range(99) < 5);
		end
	endtask

	// hold until the block has drained, including dropped pixels in flight
	task automatic drain();
		while (pixel_q.size() > 0 || s_tvalid || point_q.size() > 0) @(posedge clk);
		repeat (1500) @(posedge clk);
	endtask

	initial begin
		int idle_set [4][2] = '{'{0, 0}, '{49, 0}, '{0, 49}, '{38, 38}};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity rotation (1.0 = 16384), realistic camera
		set_camera(16'd5120, 16'd3840, 24'd27962, 24'd27962,
			{16'sd100, 16'd0, 16'd0, 16'd16384}, {-16'sd50, 16'd0, 16'd16384, 16'd0},
			{16'd0, 16'd16384, 16'd0, 16'd0}, 2'd1);
		add_pixel(0, 0, 1000, 1, 24'h000000, 1'b1);
		add_pixel(4094, 4094, 65535, 255, 24'hffffff, 1'b0);
		add_pixel(0, 4094, 65535, 128, 24'h123456, 1'b0);
		add_pixel(4094, 0, 1, 1, 24'h000000, 1'b0);
		add_pixel(2, 2, 0, 255, 24'h777777, 1'b0);
		add_pixel(2, 2, 500, 0, 24'h888888, 1'b0);
		add_pixel(3, 2, 500, 9, 24'h999999, 1'b0);
		add_pixel(2, 4095, 500, 9, 24'haaaaaa, 1'b0);
		add_pixel(4095, 4095, 65535, 255, 24'hffffff, 1'b1);
		add_pixel(320, 240, 1200, 5, 24'hffffff, 1'b0);
		add_pixel(320, 240, 1200, 5, 24'h123456, 1'b0);
		add_pixel(640, 480, 800, 200, 24'h00ff00, 1'b0);
		add_pixel(100, 100, 2000, 3, 24'h0000ff, 1'b0);
		add_pixel(100, 102, 2000, 3, 24'h00ff00, 1'b0);
		drain();

		// overflow: fill all 256 entries, then bring new and old colours
		set_camera(16'hffff, 16'h0000, 24'hffffff, 24'h000000, 64'hffff_ffff_ffff_ffff,
			64'h7fff_7fff_7fff_7fff, 64'h8000_8000_8000_8000, 2'd0);
		for (int k = 0; k < 260; k++)
			add_pixel($urandom_range(4095), $urandom_range(4095), $urandom_range(65535, 1),
				$urandom_range(255, 1), 24'(k * 24'h010203 + 24'h0a0b0c), k == 0);
		add_pixel(7, 9, 300, 1, 24'h0a0b0c, 1'b0);
		add_pixel(7, 9, 300, 1, 24'hfedcba, 1'b0);
		add_pixel(7, 9, 300, 1, 24'hfedcba, 1'b1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			send_idle = idle_set[ph % 4][0];
			recv_stall = idle_set[ph % 4][1];
			case (ph)
				0: set_camera(16'd0, 16'd0, 24'd0, 24'd0, 64'd0, 64'd0, 64'd0, 2'd3);
				1: set_camera(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 2'd2);
				2: set_camera(16'hffff, 16'hffff, 24'hffffff, 24'hffffff,
					64'h7fff_7fff_7fff_7fff, 64'h8000_8000_8000_8000,
					64'h7fff_8000_7fff_8000, 2'd0);
				default: set_camera(16'($urandom_range(12000)), 16'($urandom_range(9000)),
					24'($urandom_range(60000, 10000)), 24'($urandom_range(60000, 10000)),
					{16'($urandom), 16'd0, 16'($urandom_range(20000) - 10000), 16'd16384},
					{16'($urandom), 16'd0, 16'd16384, 16'($urandom_range(2000) - 1000)},
					{16'($urandom), 16'd16384, 16'($urandom_range(2000) - 1000), 16'd0},
					2'($urandom_range(1)));
			endcase
			add_random(45);
			drain();
		end

		$display("Sent %0d pixels over eight camera settings and four flow-control mixes;",
			pixels_sent);
		$display("checked %0d points, %0d of them with a full colour table.",
			points_seen, overflows_seen);
		if (errors == 0 && point_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/dpp_pkg.sv
rtl/dpp_front.sv
rtl/dpp_fifo.sv
rtl/dpp_back.sv
rtl/depth_pixel_to_point_with_label.sv
tb/depth_pixel_to_point_with_label_tb.sv
